/* sv/deq_pkg.sv */
// shared types and codes for the deque with value search
// no dependencies; imported by deq_mem, deq_ctrl, deque_with_value_search and the testbench
package deq_pkg;

  localparam int DATA_W  = 32;
  localparam int COUNT_W = 5;
  localparam int OP_W    = 3;
  localparam int STAT_W  = 2;
  // widest slot address over the supported capacity range
  localparam int MAX_AW  = 10;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_CONTAINS   = 3'd4;
  localparam logic [OP_W-1:0] OP_REMOVE     = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // one write port and two read ports of the slot memory
  typedef struct packed {
    logic              we;
    logic [MAX_AW-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [MAX_AW-1:0] raddr0;
    logic [MAX_AW-1:0] raddr1;
  } mem_req_t;

  // finished result handed from the sequencer to the output register
  typedef struct packed {
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
    logic [COUNT_W-1:0]       entry_count;
    logic                     found;
    logic [STAT_W-1:0]        status;
  } res_t;

endpackage

/* sv/deque_with_value_search.sv */
// top level of the deque with value search: stream ports and result register
// depends on deq_pkg, deq_mem and deq_ctrl
//
// Usage: one slave-side transaction carries one operation, its code in s_tuser
// and its value in s_tdata. Each operation yields exactly one master-side
// transaction with the front and back values, count, found flag and status
// as the deque stands after the operation.
// Push, pop and unused codes go from acceptance straight to the result, and a
// new operation is taken only once that result is handed on: the update and
// the reads of front and back go to the slot memory together, and its
// registered read data then feeds the result.
// Contains compares the entries from the front (one memory read per cycle)
// until a match or the back, then passes a fetch state; on an empty deque it
// goes straight to the result. Remove then moves each entry behind the match
// toward the front, each move a read followed by a write through the memory port.
// Reset empties the deque at once; slot contents are not cleared.
// A result waiting in the output register does not block the next operation;
// if the receiver still stalls when that operation is done, the block holds
// it and s_tready stays low until the register frees.
module deque_with_value_search #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // value[31:0]
  input  logic [2:0]  s_tuser,   // operation[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata    // front_value[31:0], back_value[63:32],
                                 // entry_count[68:64], found[69], status[71:70]
);
  import deq_pkg::*;

  mem_req_t          mreq;
  logic [DATA_W-1:0] rdata0;
  logic [DATA_W-1:0] rdata1;
  logic              res_valid;
  logic              res_ready;
  res_t              res;
  res_t              out_q;

  deq_mem #(
    .DEPTH (CAPACITY)
  ) u_mem (
    .clk    (clk),
    .req    (mreq),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  deq_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (s_tuser),
    .in_value  (s_tdata),
    .mreq      (mreq),
    .rdata0    (rdata0),
    .rdata1    (rdata1),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register is free when empty or being drained
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  // pack the result, first field lowest
  assign m_tdata = {out_q.status, out_q.found, out_q.entry_count,
                    out_q.back_value, out_q.front_value};

endmodule

/* sv/deq_mem.sv */
// slot memory: one write port, two registered read ports, write-first on a collision
// depends on deq_pkg for the request struct
module deq_mem #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  deq_pkg::mem_req_t        req,
  output logic [deq_pkg::DATA_W-1:0] rdata0,
  output logic [deq_pkg::DATA_W-1:0] rdata1
);
  import deq_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [AW-1:0]     wa;
  logic [AW-1:0]     ra0;
  logic [AW-1:0]     ra1;

  assign wa  = req.waddr[AW-1:0];
  assign ra0 = req.raddr0[AW-1:0];
  assign ra1 = req.raddr1[AW-1:0];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[wa] <= req.wdata;
    end
  end

  // read ports, new data forwarded when the same slot is written
  always_ff @(posedge clk) begin
    rdata0 <= (req.we && (wa == ra0)) ? req.wdata : mem[ra0];
    rdata1 <= (req.we && (wa == ra1)) ? req.wdata : mem[ra1];
  end

endmodule

/* sv/deq_ctrl.sv */
// sequencer of the deque: ring pointers, push/pop fast path, search and shift loops
// depends on deq_pkg; drives the request port of deq_mem
module deq_ctrl #(
  parameter int CAPACITY = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [deq_pkg::OP_W-1:0]      in_op,
  input  logic [deq_pkg::DATA_W-1:0]    in_value,
  output deq_pkg::mem_req_t             mreq,
  input  logic [deq_pkg::DATA_W-1:0]    rdata0,
  input  logic [deq_pkg::DATA_W-1:0]    rdata1,
  output logic                          res_valid,
  input  logic                          res_ready,
  output deq_pkg::res_t                 res
);
  import deq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_SCAN     = 6'b000010,
    S_SHIFT_RD = 6'b000100,
    S_SHIFT_WR = 6'b001000,
    S_FETCH    = 6'b010000,
    S_DONE     = 6'b100000
  } state_t;

  state_t              state, state_next;
  logic [AW-1:0]       head, head_next;
  logic [CW-1:0]       occ, occ_next;
  logic [CW-1:0]       idx, idx_next;
  logic [OP_W-1:0]     op_q, op_q_next;
  logic [DATA_W-1:0]   val_q, val_q_next;
  logic                found_q, found_q_next;
  logic [STAT_W-1:0]   status_q, status_q_next;

  logic                accept;
  logic [CW-1:0]       idx_inc;
  logic [AW-1:0]       we_addr;
  logic [AW-1:0]       ra0, ra1;
  logic [31:0]         occ_ext;

  // slot of a logical position counted from a base slot
  function automatic logic [AW-1:0] ring(input logic [AW-1:0] base, input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(CAPACITY)) begin
      sum = sum - (CW+1)'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

  // back position offset, guarded for an empty deque
  function automatic logic [CW-1:0] last_off(input logic [CW-1:0] n);
    return (n == '0) ? '0 : n - CW'(1);
  endfunction

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign idx_inc  = idx + CW'(1);

  // next state, pointer updates and memory requests
  always_comb begin
    state_next    = state;
    head_next     = head;
    occ_next      = occ;
    idx_next      = idx;
    op_q_next     = op_q;
    val_q_next    = val_q;
    found_q_next  = found_q;
    status_q_next = status_q;
    mreq.we       = 1'b0;
    we_addr       = '0;
    mreq.wdata    = in_value;
    ra0           = head;
    ra1           = ring(head, last_off(occ));

    case (state)
      S_IDLE: begin
        if (accept) begin
          op_q_next     = in_op;
          val_q_next    = in_value;
          found_q_next  = 1'b0;
          status_q_next = ST_OK;
          idx_next      = '0;
          state_next    = S_DONE;
          case (in_op)
            OP_PUSH_FRONT: begin
              if (occ >= CW'(CAPACITY)) begin
                status_q_next = ST_FULL;
              end else begin
                head_next = (head == '0) ? AW'(CAPACITY - 1) : head - AW'(1);
                occ_next  = occ + CW'(1);
                mreq.we   = 1'b1;
                we_addr   = head_next;
              end
            end
            OP_PUSH_BACK: begin
              if (occ >= CW'(CAPACITY)) begin
                status_q_next = ST_FULL;
              end else begin
                occ_next = occ + CW'(1);
                mreq.we  = 1'b1;
                we_addr  = ring(head, occ);
              end
            end
            OP_POP_FRONT: begin
              if (occ == '0) begin
                status_q_next = ST_EMPTY;
              end else begin
                head_next = ring(head, CW'(1));
                occ_next  = occ - CW'(1);
              end
            end
            OP_POP_BACK: begin
              if (occ == '0) begin
                status_q_next = ST_EMPTY;
              end else begin
                occ_next = occ - CW'(1);
              end
            end
            OP_CONTAINS, OP_REMOVE: begin
              if (occ != '0) begin
                state_next = S_SCAN;
              end
            end
            default: begin
            end
          endcase
          // front and back of the updated deque, read alongside the write
          ra0 = head_next;
          ra1 = ring(head_next, last_off(occ_next));
        end
      end

      // compare the slot read last cycle, read the next one
      S_SCAN: begin
        ra0 = ring(head, idx_inc);
        if (rdata0 == val_q) begin
          found_q_next = 1'b1;
          state_next   = (op_q == OP_REMOVE) ? S_SHIFT_RD : S_FETCH;
        end else if (idx_inc == occ) begin
          state_next = S_FETCH;
        end else begin
          idx_next = idx_inc;
        end
      end

      // close the gap: read the entry behind the hole
      S_SHIFT_RD: begin
        if (idx_inc < occ) begin
          ra0        = ring(head, idx_inc);
          state_next = S_SHIFT_WR;
        end else begin
          occ_next   = occ - CW'(1);
          state_next = S_FETCH;
        end
      end

      // move it one place toward the front
      S_SHIFT_WR: begin
        mreq.we    = 1'b1;
        we_addr    = ring(head, idx);
        mreq.wdata = rdata0;
        idx_next   = idx_inc;
        state_next = S_SHIFT_RD;
      end

      S_FETCH: begin
        state_next = S_DONE;
      end

      // reads repeat every cycle here, so the data holds while stalled
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // slot addresses widened to the request port
    mreq.waddr  = MAX_AW'(we_addr);
    mreq.raddr0 = MAX_AW'(ra0);
    mreq.raddr1 = MAX_AW'(ra1);
  end

  // result of the finished transaction
  assign occ_ext         = 32'(occ);
  assign res_valid       = (state == S_DONE);
  assign res.front_value = (occ == '0) ? '0 : rdata0;
  assign res.back_value  = (occ == '0) ? '0 : rdata1;
  assign res.entry_count = occ_ext[COUNT_W-1:0];
  assign res.found       = found_q;
  assign res.status      = status_q;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      occ   <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      occ   <= occ_next;
    end
  end

  // per-transaction registers
  always_ff @(posedge clk) begin
    idx      <= idx_next;
    op_q     <= op_q_next;
    val_q    <= val_q_next;
    found_q  <= found_q_next;
    status_q <= status_q_next;
  end

  // fill level and front pointer stay inside the ring
  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    occ <= CW'(CAPACITY))
    else $error("occupancy above capacity");

  a_head_range: assert property (@(posedge clk) disable iff (rst)
    32'(head) < 32'(CAPACITY))
    else $error("front pointer outside the ring");

  // slots are written only by a push or by the shift loop
  a_write_src: assert property (@(posedge clk) disable iff (rst)
    mreq.we |-> (accept || (state == S_SHIFT_WR)))
    else $error("slot write outside push or shift");

  // a stalled result stays offered
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(occ) && $stable(head)))
    else $error("pending result dropped or state moved");

  // an accepted push into a non-full deque grows it by one
  a_push_grow: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_op == OP_PUSH_BACK || in_op == OP_PUSH_FRONT) && (occ < CW'(CAPACITY)))
    |=> (occ == $past(occ) + CW'(1)))
    else $error("push did not grow the deque");

endmodule

/* tb/tb_deque_with_value_search.sv */
`timescale 1ns / 1ps
// self-checking testbench for deque_with_value_search: directed and random deque operations
// checked against an in-bench model of the ring; depends on deq_pkg and the deque RTL
module tb_deque_with_value_search;
  import deq_pkg::*;

  localparam int DEPTH         = 16;
  localparam int RANDOM_ITEMS  = 1850;
  localparam int SETTLE_CYCLES = 100;
  localparam int TIMEOUT_NS    = 10_000_000;

  // operation codes the block treats as no-ops
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  // pacing sets: receiver slow / sender slow / both at full rate
  localparam int PACE_RX_SLOW = 0;
  localparam int PACE_TX_SLOW = 1;
  localparam int PACE_FULL    = 2;

  typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIXED} burst_kind_t;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] value;
    int                pace;
    bit                wait_empty;
  } deque_cmd_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [31:0]        s_tdata = '0;   // value[31:0]
  logic [2:0]         s_tuser = '0;   // operation[2:0]
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [71:0]        m_tdata;        // front_value[31:0], back_value[63:32],
                                      // entry_count[68:64], found[69], status[71:70]

  deque_cmd_t         op_backlog[$];
  res_t               predicted_views[$];
  logic [DATA_W-1:0]  value_pool[8];
  int                 active_pace = PACE_RX_SLOW;
  int                 mismatch_count = 0;

  // model of the ring
  logic [DATA_W-1:0]  ring_model[DEPTH];
  int unsigned        ring_head = 0;
  int unsigned        ring_fill = 0;

  deque_with_value_search #(
    .CAPACITY(DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  function automatic int unsigned ring_slot(input int unsigned offset);
    return (ring_head + offset) % DEPTH;
  endfunction

  // percent of cycles a side holds off under a pacing set
  function automatic int idle_pct(input bit sender, input int pace);
    if (pace == PACE_FULL) return 0;
    if ((pace == PACE_RX_SLOW) == sender) return 18;
    return 62;
  endfunction

  // apply one operation to the model and queue the deque view it leaves
  task automatic model_deque_op(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val);
    res_t view;
    int   hit;
    view = '0;
    hit  = -1;
    case (op)
      OP_PUSH_FRONT: begin
        if (ring_fill >= DEPTH) begin
          view.status = ST_FULL;
        end else begin
          ring_head = (ring_head + DEPTH - 1) % DEPTH;
          ring_model[ring_head] = val;
          ring_fill++;
        end
      end
      OP_PUSH_BACK: begin
        if (ring_fill >= DEPTH) begin
          view.status = ST_FULL;
        end else begin
          ring_model[ring_slot(ring_fill)] = val;
          ring_fill++;
        end
      end
      OP_POP_FRONT: begin
        if (ring_fill == 0) begin
          view.status = ST_EMPTY;
        end else begin
          ring_head = ring_slot(1);
          ring_fill--;
        end
      end
      OP_POP_BACK: begin
        if (ring_fill == 0) view.status = ST_EMPTY;
        else ring_fill--;
      end
      OP_CONTAINS, OP_REMOVE: begin
        for (int i = 0; i < ring_fill; i++)
          if (hit < 0 && ring_model[ring_slot(i)] == val) hit = i;
        view.found = (hit >= 0);
        // close the gap behind the first match
        if (op == OP_REMOVE && hit >= 0) begin
          for (int j = hit; j + 1 < ring_fill; j++)
            ring_model[ring_slot(j)] = ring_model[ring_slot(j + 1)];
          ring_fill--;
        end
      end
      default: begin
      end
    endcase
    if (ring_fill != 0) begin
      view.front_value = ring_model[ring_slot(0)];
      view.back_value  = ring_model[ring_slot(ring_fill - 1)];
    end
    view.entry_count = ring_fill[COUNT_W-1:0];
    predicted_views.push_back(view);
  endtask

  task automatic enqueue_op(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val,
                            input int pace, input bit wait_empty);
    deque_cmd_t cmd;
    cmd.op         = op;
    cmd.value      = val;
    cmd.pace       = pace;
    cmd.wait_empty = wait_empty;
    op_backlog.push_back(cmd);
  endtask

  // mostly values from a small pool so searches and removals hit
  function automatic logic [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return value_pool[$urandom_range(0, 7)];
    if (r == 6) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7fff_ffff;
        2:       return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [OP_W-1:0] pick_op(input burst_kind_t kind);
    int r;
    int push_w;
    int pop_w;
    int search_w;
    r = $urandom_range(0, 99);
    case (kind)
      BURST_FILL:  begin push_w = 72; pop_w = 8;  end
      BURST_DRAIN: begin push_w = 20; pop_w = 60; end
      default:     begin push_w = 30; pop_w = 24; end
    endcase
    search_w = (97 - push_w - pop_w) / 2;
    if (r < push_w) return r[0] ? OP_PUSH_BACK : OP_PUSH_FRONT;
    if (r < push_w + pop_w) return r[0] ? OP_POP_BACK : OP_POP_FRONT;
    if (r < push_w + pop_w + search_w) return OP_CONTAINS;
    if (r < 97) return OP_REMOVE;
    return (r == 99) ? OP_SPARE_7 : OP_SPARE_6;
  endfunction

  // sender: presents backlog items, runs the model on each accepted transaction
  always @(posedge clk) begin
    deque_cmd_t nxt;
    logic       hold_valid;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) model_deque_op(s_tuser, s_tdata);
      hold_valid = s_tvalid && !s_tready;
      if (!hold_valid) begin
        if (op_backlog.size() != 0 &&
            !(op_backlog[0].wait_empty && predicted_views.size() != 0) &&
            $urandom_range(0, 99) >= idle_pct(1'b1, op_backlog[0].pace)) begin
          nxt = op_backlog.pop_front();
          s_tvalid    <= 1'b1;
          s_tdata     <= nxt.value;
          s_tuser     <= nxt.op;
          active_pace <= nxt.pace;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%08h, actual 0x%08h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // receiver: checks each result transaction against the oldest prediction
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (predicted_views.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual 0x%018h", $time, m_tdata);
          mismatch_count++;
        end else begin
          want = predicted_views.pop_front();
          compare_field("front_value", want.front_value, m_tdata[31:0]);
          compare_field("back_value",  want.back_value,  m_tdata[63:32]);
          compare_field("entry_count", 32'(want.entry_count), 32'(m_tdata[68:64]));
          compare_field("found",       32'(want.found),       32'(m_tdata[69]));
          compare_field("status",      32'(want.status),      32'(m_tdata[71:70]));
        end
      end
      m_tready <= ($urandom_range(0, 99) >= idle_pct(1'b0, active_pace));
    end
  end

  // stimulus, reset and end of run
  initial begin
    burst_kind_t kind;
    int          n;
    int          len;
    int          pace;
    int          last_pace;
    foreach (value_pool[k]) value_pool[k] = $urandom;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;

    // empty deque: refused pops, searches that miss, spare codes
    enqueue_op(OP_POP_FRONT, 32'h0000_0000, PACE_RX_SLOW, 1'b0);
    enqueue_op(OP_POP_BACK,  32'hffff_ffff, PACE_RX_SLOW, 1'b0);
    enqueue_op(OP_CONTAINS,  32'h0000_0000, PACE_RX_SLOW, 1'b0);
    enqueue_op(OP_REMOVE,    32'h0000_0000, PACE_RX_SLOW, 1'b0);
    enqueue_op(OP_SPARE_6,   32'h1234_5678, PACE_RX_SLOW, 1'b0);
    enqueue_op(OP_SPARE_7,   32'hffff_ffff, PACE_RX_SLOW, 1'b0);
    // extreme values at both ends, then a duplicate
    enqueue_op(OP_PUSH_FRONT, 32'h8000_0000, PACE_RX_SLOW, 1'b0);
    enqueue_op(OP_PUSH_BACK,  32'h7fff_ffff, PACE_RX_SLOW, 1'b0);
    enqueue_op(OP_PUSH_FRONT, 32'hffff_ffff, PACE_RX_SLOW, 1'b0);
    enqueue_op(OP_PUSH_BACK,  32'hffff_ffff, PACE_RX_SLOW, 1'b0);
    enqueue_op(OP_PUSH_BACK,  32'h0000_0000, PACE_RX_SLOW, 1'b0);
    enqueue_op(OP_CONTAINS,   32'hffff_ffff, PACE_RX_SLOW, 1'b0);
    enqueue_op(OP_CONTAINS,   32'h1234_5678, PACE_RX_SLOW, 1'b0);
    enqueue_op(OP_SPARE_6,    32'h0000_0000, PACE_RX_SLOW, 1'b0);
    // duplicate removal takes the front copy only
    enqueue_op(OP_REMOVE,     32'hffff_ffff, PACE_RX_SLOW, 1'b0);
    enqueue_op(OP_CONTAINS,   32'hffff_ffff, PACE_RX_SLOW, 1'b0);
    enqueue_op(OP_REMOVE,     32'h0000_0000, PACE_RX_SLOW, 1'b0);
    enqueue_op(OP_REMOVE,     32'h5555_aaaa, PACE_RX_SLOW, 1'b0);
    enqueue_op(OP_POP_BACK,   32'h0000_0000, PACE_RX_SLOW, 1'b0);
    enqueue_op(OP_POP_FRONT,  32'h0000_0000, PACE_RX_SLOW, 1'b0);
    enqueue_op(OP_POP_FRONT,  32'h0000_0000, PACE_RX_SLOW, 1'b0);
    enqueue_op(OP_POP_BACK,   32'h0000_0000, PACE_RX_SLOW, 1'b0);

    // random part opens by pushing past capacity
    for (n = 0; n < 20; n++)
      enqueue_op($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_value(),
                 PACE_RX_SLOW, 1'b0);
    last_pace = PACE_RX_SLOW;
    while (n < RANDOM_ITEMS) begin
      kind = burst_kind_t'($urandom_range(0, 2));
      len  = $urandom_range(6, 40);
      for (int j = 0; j < len && n < RANDOM_ITEMS; j++) begin
        pace = (n * 3) / RANDOM_ITEMS;
        enqueue_op(pick_op(kind), pick_value(), pace,
                   (pace != last_pace) || ($urandom_range(0, 199) == 0));
        last_pace = pace;
        n++;
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (op_backlog.size() != 0 || s_tvalid) @(posedge clk);
    while (predicted_views.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_deque_with_value_search passed");
    end else begin
      $display("tb_deque_with_value_search failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("%0t ns: timeout, %0d results outstanding", $time, predicted_views.size());
    $display("tb_deque_with_value_search failed");
    $finish;
  end

endmodule

/* filelist.f */
sv/deq_pkg.sv
sv/deq_mem.sv
sv/deq_ctrl.sv
sv/deque_with_value_search.sv
tb/tb_deque_with_value_search.sv
